[rtl/core/lpnt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package lpnt_pkg;
   localparam int LOST_ENTRIES = 32;
   localparam int IDX_W = $clog2(LOST_ENTRIES);
   localparam logic [3:0] GAP_CAP = 4'hf;

   typedef enum logic [1:0] {
      CMD_CHECK = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_NONE = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STG_NEW = 2'd0,
      STG_NACK1 = 2'd1,
      STG_NACK2 = 2'd2,
      STG_PLI = 2'd3
   } stage_type;

   typedef enum logic [0:0] {
      CSR_FRAME_INTERVAL = 1'b0,
      CSR_RESPONSE_WAIT = 1'b1
   } csr_idx_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DROP,
      ST_SEARCH,
      ST_UPDATE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic drop;
      logic search;
      logic update;
      logic finish;
   } ctrl_type;

   typedef struct packed {
      logic run_gap;
      logic last_k;
   } status_type;
endpackage
`default_nettype wire

[rtl/core/lost_packet_nack_tracker_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// Lost-packet NACK tracker. Pulse start with busy low; one result beat per
// item follows on rsp_valid, held one cycle only - the receiver cannot stall.
// A check steps DROP, SEARCH/UPDATE per lost number (gap capped at 15),
// FINISH; others skip both. Each gap sequence needs one table search and one
// time-mark memory read/update. csr_ready is always high; write only idle.
module lost_packet_nack_tracker_unit import lpnt_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_command,
   input  wire logic [15:0] req_seq_num,
   input  wire logic [15:0] req_last_seq,
   input  wire logic [31:0] req_now_ms,
   output logic             rsp_valid,
   output logic             rsp_nack_valid,
   output logic [15:0]      rsp_nack_first_seq,
   output logic [13:0]      rsp_nack_mask,
   output logic [3:0]       rsp_second_nack_count,
   output logic             rsp_pli_request,
   output logic [3:0]       rsp_new_losses,
   output logic [3:0]       rsp_dropped_losses,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);
   ctrl_type   ctrl;
   status_type status;

   assign csr_ready = 1'b1;

   lpnt_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .status(status),
      .ctrl(ctrl), .busy(busy)
   );

   lpnt_dpath u_dpath (
      .clock(clock), .reset(reset), .ctrl(ctrl), .status(status),
      .req_command(req_command), .req_seq_num(req_seq_num),
      .req_last_seq(req_last_seq), .req_now_ms(req_now_ms),
      .csr_valid(csr_valid), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .rsp_valid(rsp_valid), .rsp_nack_valid(rsp_nack_valid),
      .rsp_nack_first_seq(rsp_nack_first_seq), .rsp_nack_mask(rsp_nack_mask),
      .rsp_second_nack_count(rsp_second_nack_count),
      .rsp_pli_request(rsp_pli_request), .rsp_new_losses(rsp_new_losses),
      .rsp_dropped_losses(rsp_dropped_losses)
   );

   a_beat_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("result beat while busy");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("accepted item not busy");
   a_single_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("back-to-back result beats");
endmodule
`default_nettype wire

[rtl/core/lpnt_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module lpnt_ctrl import lpnt_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   input  wire status_type status,
   output ctrl_type        ctrl,
   output logic            busy
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_DROP;
         end
         ST_DROP: begin
            state_in = status.run_gap ? ST_SEARCH : ST_FINISH;
         end
         ST_SEARCH: state_in = ST_UPDATE;
         ST_UPDATE: begin
            state_in = status.last_k ? ST_FINISH : ST_SEARCH;
         end
         ST_FINISH: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl = '0;
      busy = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            ctrl.load = start;
         end
         ST_DROP: ctrl.drop = 1'b1;
         ST_SEARCH: ctrl.search = 1'b1;
         ST_UPDATE: ctrl.update = 1'b1;
         ST_FINISH: ctrl.finish = 1'b1;
         default: busy = 1'b1;
      endcase
   end
endmodule
`default_nettype wire

[rtl/core/lpnt_dpath.sv]
`timescale 1ns / 1ps
`default_nettype none
module lpnt_dpath import lpnt_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire ctrl_type    ctrl,
   output status_type       status,
   input  wire logic [1:0]  req_command,
   input  wire logic [15:0] req_seq_num,
   input  wire logic [15:0] req_last_seq,
   input  wire logic [31:0] req_now_ms,
   input  wire logic        csr_valid,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata,
   output logic             rsp_valid,
   output logic             rsp_nack_valid,
   output logic [15:0]      rsp_nack_first_seq,
   output logic [13:0]      rsp_nack_mask,
   output logic [3:0]       rsp_second_nack_count,
   output logic             rsp_pli_request,
   output logic [3:0]       rsp_new_losses,
   output logic [3:0]       rsp_dropped_losses
);
   logic [9:0]  fi_ff;
   logic [15:0] rw_ff;
   logic [1:0]  cmd_ff;
   logic [15:0] seq_ff, pid_ff, pli_seq_ff;
   logic [31:0] now_ff;
   logic [3:0]  gap_ff, k_ff, cnt_ff, second_ff, added_ff, dropped_ff;
   logic        pli_ff;
   logic [LOST_ENTRIES-1:0] valid_ff;
   logic [15:0] eseq_ff [LOST_ENTRIES];
   stage_type   stage_ff [LOST_ENTRIES];
   logic [31:0] mark_mem [LOST_ENTRIES];
   logic [31:0] mark_rd_ff;
   logic        hit_ff, free_ok_ff;
   logic [IDX_W-1:0] hit_idx_ff, free_idx_ff;
   logic [15:0] ls_ff;

   logic [15:0] pid_in, diff, ls_in, pid_fin;
   logic [3:0]  gap_in;
   logic        hit_in, free_ok_in;
   logic [IDX_W-1:0] hit_idx_in, free_idx_in, widx;
   logic [31:0] elapsed;
   stage_type   st;
   logic        adv0, advn, wr_mark;
   logic [13:0] mask;

   assign pid_in = req_last_seq + 16'd1;
   assign diff = req_seq_num - pid_in;
   always_comb begin
      if (pid_in == req_seq_num || req_last_seq == req_seq_num) gap_in = '0;
      else if (diff > 16'(GAP_CAP)) gap_in = GAP_CAP;
      else gap_in = diff[3:0];
   end

   assign status.run_gap = (cmd_ff == CMD_CHECK) && (gap_ff != '0);
   assign status.last_k = (k_ff + 4'd1) == gap_ff;

   assign ls_in = pid_ff + 16'(k_ff);
   always_comb begin
      hit_in = 1'b0;
      free_ok_in = 1'b0;
      hit_idx_in = '0;
      free_idx_in = '0;
      for (int i = LOST_ENTRIES - 1; i >= 0; i--) begin
         if (valid_ff[i] && eseq_ff[i] == ls_in) begin
            hit_in = 1'b1;
            hit_idx_in = IDX_W'(i);
         end
         if (!valid_ff[i]) begin
            free_ok_in = 1'b1;
            free_idx_in = IDX_W'(i);
         end
      end
   end

   assign elapsed = now_ff - mark_rd_ff;
   assign st = stage_ff[hit_idx_ff];
   assign adv0 = hit_ff && st == STG_NEW && elapsed >= 32'(fi_ff);
   assign advn = hit_ff && st != STG_NEW && elapsed >= 32'(rw_ff);
   assign wr_mark = ctrl.update && (adv0 || advn || (!hit_ff && free_ok_ff));
   assign widx = hit_ff ? hit_idx_ff : free_idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fi_ff <= 10'd66;
         rw_ff <= '0;
      end else if (csr_valid) begin
         if (csr_index == 2'(CSR_FRAME_INTERVAL)) fi_ff <= csr_wdata[9:0];
         else if (csr_index == 2'(CSR_RESPONSE_WAIT)) rw_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.search) mark_rd_ff <= mark_mem[hit_idx_in];
      if (wr_mark) mark_mem[widx] <= now_ff;
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         cmd_ff <= req_command;
         seq_ff <= req_seq_num;
         pid_ff <= pid_in;
         now_ff <= req_now_ms;
         gap_ff <= gap_in;
      end
      if (ctrl.search) begin
         hit_ff <= hit_in;
         free_ok_ff <= free_ok_in;
         hit_idx_ff <= hit_idx_in;
         free_idx_ff <= free_idx_in;
         ls_ff <= ls_in;
      end
      if (ctrl.update && !hit_ff && free_ok_ff) begin
         eseq_ff[free_idx_ff] <= ls_ff;
         stage_ff[free_idx_ff] <= STG_NEW;
      end else if (ctrl.update && adv0) begin
         stage_ff[hit_idx_ff] <= STG_NACK1;
      end else if (ctrl.update && advn && st == STG_NACK1) begin
         stage_ff[hit_idx_ff] <= STG_NACK2;
      end else if (ctrl.update && advn && st == STG_NACK2) begin
         stage_ff[hit_idx_ff] <= STG_PLI;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         k_ff <= '0;
         cnt_ff <= '0;
         second_ff <= '0;
         added_ff <= '0;
         dropped_ff <= '0;
         pli_ff <= 1'b0;
         pli_seq_ff <= '0;
      end else begin
         if (ctrl.load) begin
            k_ff <= '0;
            cnt_ff <= '0;
            second_ff <= '0;
            added_ff <= '0;
            dropped_ff <= '0;
            pli_ff <= 1'b0;
            pli_seq_ff <= '0;
         end
         if (ctrl.drop) begin
            for (int i = 0; i < LOST_ENTRIES; i++) begin
               unique case (cmd_ff)
                  CMD_CHECK: if (eseq_ff[i] == seq_ff) valid_ff[i] <= 1'b0;
                  CMD_REMOVE: if (eseq_ff[i] <= seq_ff) valid_ff[i] <= 1'b0;
                  CMD_CLEAR: valid_ff[i] <= 1'b0;
                  default: ;
               endcase
            end
         end
         if (ctrl.update) begin
            k_ff <= k_ff + 4'd1;
            if (!hit_ff) begin
               if (free_ok_ff) begin
                  valid_ff[free_idx_ff] <= 1'b1;
                  added_ff <= added_ff + 4'd1;
               end else begin
                  dropped_ff <= dropped_ff + 4'd1;
               end
            end else if (adv0) begin
               cnt_ff <= cnt_ff + 4'd1;
            end else if (advn) begin
               if (st == STG_NACK1) begin
                  second_ff <= second_ff + 4'd1;
                  cnt_ff <= cnt_ff + 4'd1;
               end else begin
                  pli_seq_ff <= ls_ff;
                  if (st == STG_NACK2) pli_ff <= 1'b1;
               end
            end
         end
      end
   end

   assign pid_fin = (pli_seq_ff > pid_ff) ? pli_seq_ff + 16'd1 : pid_ff;
   always_comb begin
      for (int i = 0; i < 14; i++) mask[i] = (5'(i) + 5'd1) < 5'(cnt_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= ctrl.finish;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.finish) begin
         rsp_nack_valid <= (pid_fin != seq_ff) && (cnt_ff != '0);
         rsp_nack_first_seq <= ((pid_fin != seq_ff) && (cnt_ff != '0)) ? pid_fin : '0;
         rsp_nack_mask <= ((pid_fin != seq_ff) && (cnt_ff != '0)) ? mask : '0;
         rsp_second_nack_count <= second_ff;
         rsp_pli_request <= pli_ff;
         rsp_new_losses <= added_ff;
         rsp_dropped_losses <= dropped_ff;
      end
   end
endmodule
`default_nettype wire

[tb/lost_packet_nack_tracker_unit_tb.sv]
`timescale 1ns / 1ps
module lost_packet_nack_tracker_unit_tb;
   import lpnt_pkg::*;

   typedef struct packed {
      logic        nack_valid;
      logic [15:0] first_seq;
      logic [13:0] mask;
      logic [3:0]  second_cnt;
      logic        pli;
      logic [3:0]  new_cnt;
      logic [3:0]  drop_cnt;
   } nack_result_type;

   class nack_scoreboard;
      logic [9:0]  frame_ms;
      logic [15:0] resp_ms;
      logic        ent_valid [LOST_ENTRIES];
      logic [15:0] ent_seq [LOST_ENTRIES];
      logic [31:0] ent_mark [LOST_ENTRIES];
      stage_type   ent_stage [LOST_ENTRIES];
      nack_result_type pending[$];
      int mismatches;

      function void init();
         frame_ms = 10'd66;
         resp_ms = 16'd0;
         mismatches = 0;
         for (int i = 0; i < LOST_ENTRIES; i++) begin
            ent_valid[i] = 1'b0;
            ent_seq[i] = '0;
            ent_mark[i] = '0;
            ent_stage[i] = STG_NEW;
         end
      endfunction

      function void write_reg(csr_idx_type idx, logic [15:0] v);
         if (idx == CSR_FRAME_INTERVAL) frame_ms = v[9:0];
         else resp_ms = v;
      endfunction

      function void note_request(cmd_type cmd, logic [15:0] seq, logic [15:0] last,
                                 logic [31:0] now);
         nack_result_type r;
         logic [15:0] pid, gap, pli_seq, ls;
         int nack_cnt, second, added, dropped, hit, freei;
         logic pli;
         logic [31:0] elapsed;
         r = '{0, 0, 0, 0, 0, 0, 0};
         pli_seq = 0; nack_cnt = 0; second = 0; added = 0; dropped = 0; pli = 0;
         if (cmd == CMD_REMOVE) begin
            for (int i = 0; i < LOST_ENTRIES; i++)
               if (ent_valid[i] && ent_seq[i] <= seq) ent_valid[i] = 1'b0;
         end else if (cmd == CMD_CLEAR) begin
            for (int i = 0; i < LOST_ENTRIES; i++) ent_valid[i] = 1'b0;
         end else if (cmd == CMD_CHECK) begin
            for (int i = 0; i < LOST_ENTRIES; i++)
               if (ent_valid[i] && ent_seq[i] == seq) ent_valid[i] = 1'b0;
            pid = last + 16'd1;
            if (pid != seq && last != seq) begin
               gap = seq - pid;
               if (gap > 16'h000f) gap = 16'h000f;
               for (int k = 0; k < gap; k++) begin
                  ls = pid + k[15:0];
                  hit = -1; freei = -1;
                  for (int i = 0; i < LOST_ENTRIES; i++) begin
                     if (ent_valid[i]) begin
                        if (hit < 0 && ent_seq[i] == ls) hit = i;
                     end else if (freei < 0) begin
                        freei = i;
                     end
                  end
                  if (hit < 0) begin
                     if (freei < 0) dropped++;
                     else begin
                        ent_valid[freei] = 1'b1;
                        ent_seq[freei] = ls;
                        ent_mark[freei] = now;
                        ent_stage[freei] = STG_NEW;
                        added++;
                     end
                  end else begin
                     elapsed = now - ent_mark[hit];
                     if (ent_stage[hit] == STG_NEW) begin
                        if (elapsed >= {22'd0, frame_ms}) begin
                           ent_mark[hit] = now;
                           ent_stage[hit] = STG_NACK1;
                           nack_cnt++;
                        end
                     end else if (elapsed >= {16'd0, resp_ms}) begin
                        ent_mark[hit] = now;
                        if (ent_stage[hit] == STG_NACK1) begin
                           ent_stage[hit] = STG_NACK2;
                           second++; nack_cnt++;
                        end else if (ent_stage[hit] == STG_NACK2) begin
                           ent_stage[hit] = STG_PLI;
                           pli_seq = ls; pli = 1'b1;
                        end else begin
                           pli_seq = ls;
                        end
                     end
                  end
               end
               if (pli_seq > pid) pid = pli_seq + 16'd1;
               r.second_cnt = second[3:0];
               r.pli = pli;
               r.new_cnt = added[3:0];
               r.drop_cnt = dropped[3:0];
               if (pid != seq && nack_cnt > 0) begin
                  r.nack_valid = 1'b1;
                  r.first_seq = pid;
                  r.mask = (nack_cnt > 1) ? 14'((32'd1 << (nack_cnt - 1)) - 1) : '0;
               end
            end
         end
         pending.insert(pending.size(), r);
      endfunction

      function void check_result(nack_result_type got);
         nack_result_type e;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat");
            return;
         end
         e = pending[0];
         pending.delete(0);
         if (got != e) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"mismatch: exp nv%0d f%h m%h s%0d p%0d n%0d d%0d",
                         " got nv%0d f%h m%h s%0d p%0d n%0d d%0d"},
                  e.nack_valid, e.first_seq, e.mask, e.second_cnt, e.pli, e.new_cnt,
                  e.drop_cnt, got.nack_valid, got.first_seq, got.mask, got.second_cnt,
                  got.pli, got.new_cnt, got.drop_cnt);
         end
      endfunction
   endclass

   logic clock, reset, start, busy;
   logic [1:0] req_command;
   logic [15:0] req_seq_num, req_last_seq;
   logic [31:0] req_now_ms;
   logic rsp_valid, rsp_nack_valid, rsp_pli_request;
   logic [15:0] rsp_nack_first_seq;
   logic [13:0] rsp_nack_mask;
   logic [3:0] rsp_second_nack_count, rsp_new_losses, rsp_dropped_losses;
   logic csr_valid, csr_ready;
   logic [1:0] csr_index;
   logic [15:0] csr_wdata;

   nack_scoreboard sb;
   logic [15:0] stream_seq;
   logic [31:0] clock_ms;

   lost_packet_nack_tracker_unit u_dut (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("Some tests failed");
      $finish;
   end

   always @(posedge clock) begin
      nack_result_type got;
      if (!reset && rsp_valid) begin
         got.nack_valid = rsp_nack_valid;
         got.first_seq = rsp_nack_first_seq;
         got.mask = rsp_nack_mask;
         got.second_cnt = rsp_second_nack_count;
         got.pli = rsp_pli_request;
         got.new_cnt = rsp_new_losses;
         got.drop_cnt = rsp_dropped_losses;
         sb.check_result(got);
      end
   end

   task automatic send_request(cmd_type cmd, logic [15:0] seq, logic [15:0] last,
                               logic [31:0] now);
      req_command = cmd; req_seq_num = seq; req_last_seq = last; req_now_ms = now;
      start = 1'b1;
      do @(posedge clock); while (busy);
      sb.note_request(cmd, seq, last, now);
      @(negedge clock);
      start = 1'b0;
   endtask

   task automatic drain();
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_csr(csr_idx_type idx, logic [15:0] v);
      csr_index = {1'b0, idx}; csr_wdata = v; csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, v);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic random_phase(int n);
      int burst;
      logic [15:0] jump;
      int r;
      burst = 0;
      for (int i = 0; i < n; i++) begin
         if (burst == 0) begin
            repeat ($urandom_range(0, 6)) @(negedge clock);
            burst = $urandom_range(1, 12);
         end
         burst--;
         r = $urandom_range(0, 99);
         clock_ms += $urandom_range(0, 120);
         if (r < 70) begin
            jump = (r < 15) ? 16'd1 : 16'($urandom_range(1, 18));
            if ($urandom_range(0, 2) == 0)
               send_request(CMD_CHECK, stream_seq + jump, stream_seq, clock_ms);
            else begin
               send_request(CMD_CHECK, stream_seq + jump,
                            stream_seq - 16'($urandom_range(0, 20)), clock_ms);
            end
            if ($urandom_range(0, 3) != 0) stream_seq += jump;
         end else if (r < 78) begin
            send_request(CMD_REMOVE, stream_seq - 16'($urandom_range(0, 40)), 16'($urandom),
                         clock_ms);
         end else if (r < 81) begin
            send_request(CMD_CLEAR, 16'($urandom), 16'($urandom), 32'($urandom));
         end else if (r < 83) begin
            send_request(CMD_NONE, 16'($urandom), 16'($urandom), 32'($urandom));
         end else begin
            send_request(CMD_CHECK, 16'($urandom), 16'($urandom), 32'($urandom));
         end
      end
   endtask

   initial begin
      sb = new();
      sb.init();
      start = 0; req_command = '0; req_seq_num = '0; req_last_seq = '0; req_now_ms = '0;
      csr_valid = 0; csr_index = '0; csr_wdata = '0;
      reset = 1;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed
      send_request(CMD_CHECK, 16'd10, 16'd0, 32'd0);
      send_request(CMD_CHECK, 16'd11, 16'd10, 32'd100);
      send_request(CMD_CHECK, 16'd10, 16'd10, 32'd100);
      send_request(CMD_CHECK, 16'd12, 16'd0, 32'd200);
      send_request(CMD_CHECK, 16'd12, 16'd0, 32'd300);
      send_request(CMD_CHECK, 16'd12, 16'd0, 32'd400);
      send_request(CMD_CHECK, 16'd12, 16'd0, 32'd500);
      send_request(CMD_CHECK, 16'h0005, 16'hfff0, 32'hffff_fff0);
      send_request(CMD_CHECK, 16'h0006, 16'hfff0, 32'h0000_0100);
      send_request(CMD_CHECK, 16'hffff, 16'h0000, 32'hffff_ffff);
      send_request(CMD_CHECK, 16'h0000, 16'hffff, 32'd0);
      send_request(CMD_CHECK, 16'd200, 16'd100, 32'd0);
      send_request(CMD_CHECK, 16'd300, 16'd250, 32'd0);
      send_request(CMD_CHECK, 16'd400, 16'd350, 32'd0);
      send_request(CMD_REMOVE, 16'd5, 16'd0, 32'd0);
      send_request(CMD_REMOVE, 16'hffff, 16'hffff, 32'd0);
      send_request(CMD_NONE, 16'hffff, 16'hffff, 32'hffff_ffff);
      send_request(CMD_CLEAR, 16'd0, 16'd0, 32'd0);
      drain();

      stream_seq = 16'($urandom); clock_ms = $urandom;
      write_csr(CSR_FRAME_INTERVAL, 16'd0);
      write_csr(CSR_RESPONSE_WAIT, 16'd0);
      random_phase(200);
      drain();
      write_csr(CSR_FRAME_INTERVAL, 16'd1000);
      write_csr(CSR_RESPONSE_WAIT, 16'hffff);
      random_phase(150);
      drain();
      write_csr(CSR_FRAME_INTERVAL, 16'($urandom_range(0, 200)) | 16'hfc00);
      write_csr(CSR_RESPONSE_WAIT, 16'($urandom_range(0, 300)));
      random_phase(300);
      drain();
      write_csr(CSR_FRAME_INTERVAL, 16'd66);
      write_csr(CSR_RESPONSE_WAIT, 16'd100);
      random_phase(250);
      drain();

      if (sb.mismatches == 0 && sb.pending.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule
